// ===== design/snt_pkg.sv =====
package snt_pkg;

  localparam int TableDepthDefault = 32;
  localparam int NameCharsDefault  = 8;
  localparam int KeyWidth          = 64;
  localparam int CmdWidth          = 3;
  localparam int IndexWidth        = 5;
  localparam int TotalWidth        = 6;

  typedef enum logic [CmdWidth-1:0] {
    CmdAppend = 3'd0,
    CmdInsert = 3'd1,
    CmdRemove = 3'd2,
    CmdSort   = 3'd3,
    CmdRead   = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    StIdle,
    StScanRd,
    StScanCmp,
    StShiftRd,
    StShiftWr,
    StSortRd,
    StSortKey,
    StSortCmp,
    StSortWr,
    StReadRd,
    StReadWait,
    StDone
  } state_e;

  // Fold 'A'..'Z' to lowercase in every byte.
  function automatic logic [KeyWidth-1:0] fold_case(input logic [KeyWidth-1:0] k);
    logic [KeyWidth-1:0] r;
    logic [7:0] c;
    r = k;
    for (int b = 0; b < KeyWidth / 8; b++) begin
      c = k[b*8 +: 8];
      if (c >= 8'h41 && c <= 8'h5a) begin
        r[b*8 +: 8] = c + 8'h20;
      end
    end
    return r;
  endfunction

endpackage

// ===== design/snt_if.sv =====
interface snt_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [snt_pkg::CmdWidth-1:0]   cmd;
  logic [snt_pkg::KeyWidth-1:0]   name_key;
  logic [snt_pkg::IndexWidth-1:0] read_index;
  modport source (output valid, cmd, name_key, read_index, input ready);
  modport sink (input valid, cmd, name_key, read_index, output ready);
endinterface

interface snt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [snt_pkg::KeyWidth-1:0]   entry_value;
  logic [snt_pkg::TotalWidth-1:0] entry_total;
  modport source (output valid, ok, entry_value, entry_total, input ready);
  modport sink (input valid, ok, entry_value, entry_total, output ready);
endinterface

// ===== design/snt_ram.sv =====
module snt_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/sorted_name_table_core.sv =====
// Commands are taken one at a time: ready is high only in idle, and a finished
// result is held until taken. The registered-read name RAM and the shared
// comparators set the pace.
// Reset: asynchronous, active low; clears the count and the sequencer, not the RAM.
module sorted_name_table_core #(
  parameter int TableDepth = snt_pkg::TableDepthDefault,
  parameter int NameChars  = snt_pkg::NameCharsDefault
) (
  input logic clk_i,
  input logic rst_ni,
  snt_cmd_if.sink   cmd_i,
  snt_rsp_if.source rsp_o
);

  localparam int AddrW  = $clog2(TableDepth);
  localparam int CntW   = $clog2(TableDepth + 1);
  localparam int KW     = snt_pkg::KeyWidth;
  localparam int IndexW = snt_pkg::IndexWidth;

  snt_pkg::state_e state_q, state_d;

  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  i_q, i_d;      // scan index or outer sort index
  logic [CntW-1:0]  j_q, j_d;      // shift index or inner sort index
  logic [KW-1:0]    key_q, key_d;  // canonical key or sort element
  logic [snt_pkg::CmdWidth-1:0] cmd_q, cmd_d;
  logic [IndexW-1:0] idx_q, idx_d;
  logic             ok_q, ok_d;
  logic [KW-1:0]    val_q, val_d;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [KW-1:0]    wdata, rdata;

  snt_ram #(.Width(KW), .Depth(TableDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Canonical form: keep top NameChars bytes, clear after first zero byte.
  logic [KW-1:0] canon;
  always_comb begin
    logic stop;
    stop  = 1'b0;
    canon = '0;
    for (int b = 0; b < 8; b++) begin
      if (b >= NameChars || cmd_i.name_key[KW-1-8*b -: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        canon[KW-1-8*b -: 8] = cmd_i.name_key[KW-1-8*b -: 8];
      end
    end
  end

  logic full;
  assign full = (count_q == CntW'(TableDepth));
  assign cmd_i.ready = (state_q == snt_pkg::StIdle);
  assign rsp_o.valid = (state_q == snt_pkg::StDone);
  assign rsp_o.ok = ok_q;
  assign rsp_o.entry_value = val_q;
  assign rsp_o.entry_total = snt_pkg::TotalWidth'(count_q);

  // Shared comparators: byte-order greater, equality and case-folded greater against the held key.
  logic gt_byte, gt_fold, eq_key;
  assign gt_byte = rdata > key_q;
  assign eq_key  = rdata == key_q;
  assign gt_fold = snt_pkg::fold_case(rdata) > snt_pkg::fold_case(key_q);

  // Next state and datapath registers.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    i_d = i_q; j_d = j_q; key_d = key_q; cmd_d = cmd_q; idx_d = idx_q;
    ok_d = ok_q; val_d = val_q;
    case (state_q)
      snt_pkg::StIdle: begin
        if (cmd_i.valid) begin
          key_d = canon; cmd_d = cmd_i.cmd; idx_d = cmd_i.read_index;
          ok_d = 1'b0; val_d = '0; i_d = '0;
          case (cmd_i.cmd)
            snt_pkg::CmdAppend: begin
              if (!full) begin
                count_d = count_q + 1'b1; ok_d = 1'b1;
              end
              state_d = snt_pkg::StDone;
            end
            snt_pkg::CmdInsert: begin
              state_d = full ? snt_pkg::StDone :
                        (count_q == '0 ? snt_pkg::StShiftWr : snt_pkg::StScanRd);
              j_d = count_q; // insert position defaults to the end
              i_d = count_q;
            end
            snt_pkg::CmdRemove:
              state_d = (count_q == '0) ? snt_pkg::StDone : snt_pkg::StScanRd;
            snt_pkg::CmdSort: begin
              ok_d = 1'b1; i_d = CntW'(1);
              state_d = (count_q > CntW'(1)) ? snt_pkg::StSortRd : snt_pkg::StDone;
            end
            snt_pkg::CmdRead:
              state_d = (32'(cmd_i.read_index) < 32'(count_q)) ?
                        snt_pkg::StReadRd : snt_pkg::StDone;
            default: state_d = snt_pkg::StDone;
          endcase
          if (cmd_i.cmd == snt_pkg::CmdInsert && !full && count_q != '0) begin
            i_d = '0;
          end
        end
      end
      snt_pkg::StScanRd: state_d = snt_pkg::StScanCmp;
      snt_pkg::StScanCmp: begin
        if (cmd_q == snt_pkg::CmdInsert) begin
          if (gt_byte) begin
            i_d = i_q; state_d = snt_pkg::StShiftRd; j_d = count_q;
          end else if (i_q + 1'b1 == count_q) begin
            i_d = count_q; j_d = count_q; state_d = snt_pkg::StShiftWr;
          end else begin
            i_d = i_q + 1'b1; state_d = snt_pkg::StScanRd;
          end
        end else begin
          if (eq_key) begin
            ok_d = 1'b1; j_d = i_q;
            if (i_q + 1'b1 == count_q) begin
              count_d = count_q - 1'b1; state_d = snt_pkg::StDone;
            end else begin
              state_d = snt_pkg::StShiftRd;
            end
          end else if (i_q + 1'b1 == count_q) begin
            state_d = snt_pkg::StDone;
          end else begin
            i_d = i_q + 1'b1; state_d = snt_pkg::StScanRd;
          end
        end
      end
      // Insert: move entry j-1 to j down to i. Remove: move j+1 to j.
      snt_pkg::StShiftRd: state_d = snt_pkg::StShiftWr;
      snt_pkg::StShiftWr: begin
        if (cmd_q == snt_pkg::CmdInsert) begin
          if (j_q == i_q) begin
            count_d = count_q + 1'b1; ok_d = 1'b1; state_d = snt_pkg::StDone;
          end else begin
            j_d = j_q - 1'b1; state_d = snt_pkg::StShiftRd;
          end
        end else begin
          if (j_q + CntW'(2) == count_q) begin
            count_d = count_q - 1'b1; state_d = snt_pkg::StDone;
          end else begin
            j_d = j_q + 1'b1; state_d = snt_pkg::StShiftRd;
          end
        end
      end
      // Insertion sort: fetch element i, then walk j down while the left entry is greater.
      snt_pkg::StSortRd: begin
        j_d = i_q;
        state_d = snt_pkg::StSortKey;
      end
      snt_pkg::StSortKey: begin
        key_d = rdata;
        state_d = snt_pkg::StSortCmp;
      end
      snt_pkg::StSortCmp: begin
        if (gt_fold) begin
          j_d = j_q - 1'b1;
          state_d = (j_q == CntW'(1)) ? snt_pkg::StSortWr : snt_pkg::StSortCmp;
        end else begin
          state_d = snt_pkg::StSortWr;
        end
      end
      snt_pkg::StSortWr: begin
        if (i_q + 1'b1 == count_q) begin
          state_d = snt_pkg::StDone;
        end else begin
          i_d = i_q + 1'b1; state_d = snt_pkg::StSortRd;
        end
      end
      snt_pkg::StReadRd: state_d = snt_pkg::StReadWait;
      snt_pkg::StReadWait: begin
        val_d = rdata; ok_d = 1'b1; state_d = snt_pkg::StDone;
      end
      snt_pkg::StDone: begin
        if (rsp_o.ready) state_d = snt_pkg::StIdle;
      end
      default: state_d = snt_pkg::StIdle;
    endcase
  end

  // RAM port control.
  always_comb begin
    we = 1'b0; waddr = AddrW'(j_q); wdata = key_q; raddr = AddrW'(i_q);
    case (state_q)
      snt_pkg::StIdle: begin
        we = cmd_i.valid && cmd_i.cmd == snt_pkg::CmdAppend && !full;
        waddr = AddrW'(count_q); wdata = canon;
      end
      snt_pkg::StScanRd: raddr = AddrW'(i_q);
      snt_pkg::StShiftRd:
        raddr = (cmd_q == snt_pkg::CmdInsert) ? AddrW'(j_q - 1'b1) : AddrW'(j_q + 1'b1);
      snt_pkg::StShiftWr: begin
        we = 1'b1; waddr = AddrW'(j_q);
        wdata = (cmd_q == snt_pkg::CmdInsert && j_q == i_q) ? key_q : rdata;
      end
      snt_pkg::StSortRd: raddr = AddrW'(i_q);
      snt_pkg::StSortKey: raddr = AddrW'(j_q - 1'b1);
      // A greater left entry moves up one place while the next one is fetched.
      snt_pkg::StSortCmp: begin
        we = gt_fold;
        waddr = AddrW'(j_q);
        wdata = rdata;
        raddr = AddrW'(j_q - CntW'(2));
      end
      snt_pkg::StSortWr: begin
        we = 1'b1; waddr = AddrW'(j_q); wdata = key_q;
      end
      snt_pkg::StReadRd: raddr = AddrW'(idx_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= snt_pkg::StIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; key_q <= key_d; cmd_q <= cmd_d; idx_q <= idx_d;
    ok_q <= ok_d; val_q <= val_d;
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth)) else $error("count beyond depth");
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != snt_pkg::StIdle && state_q != snt_pkg::StDone &&
     state_q != snt_pkg::StShiftWr && state_q != snt_pkg::StScanCmp)
    |=> $stable(count_q)) else $error("count changed mid-command");
  a_ok_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ok) |-> rsp_o.entry_value == '0)
    else $error("value on failed command");
`endif

endmodule

// ===== tb/sorted_name_table_core_tb.sv =====
module sorted_name_table_core_tb;

  localparam int Depth = snt_pkg::TableDepthDefault;
  localparam int KW = snt_pkg::KeyWidth;
  localparam int IW = snt_pkg::IndexWidth;
  localparam int CW = snt_pkg::CmdWidth;
  localparam int WatchLimit = 20000;
  localparam logic [CW-1:0] CmdUnusedLo = 3'd5;
  localparam logic [CW-1:0] CmdUnusedHi = 3'd7;

  typedef struct packed {
    logic                           ok;
    logic [KW-1:0]                  value;
    logic [snt_pkg::TotalWidth-1:0] total;
  } reply_t;

  logic clk_i;
  logic rst_ni;

  snt_cmd_if cmd_bus ();
  snt_rsp_if rsp_bus ();

  sorted_name_table_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus.sink),
    .rsp_o  (rsp_bus.source)
  );

  // Shadow copy of the table contents.
  logic [KW-1:0] shadow_names [Depth];
  int unsigned   shadow_count;
  reply_t        pending_replies [$];
  int            send_idle_pct;
  int            recv_stall_pct;
  int            error_count = 0;
  int            quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Cut a key to its name characters and clear everything after the first zero byte.
  function automatic logic [KW-1:0] trim_name(input logic [KW-1:0] k);
    logic [KW-1:0] r;
    bit            ended;
    r = '0;
    ended = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (b >= snt_pkg::NameCharsDefault || k[56-8*b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[56-8*b +: 8] = k[56-8*b +: 8];
    end
    return r;
  endfunction

  function automatic logic [KW-1:0] lower_name(input logic [KW-1:0] k);
    logic [KW-1:0] r;
    r = k;
    for (int b = 0; b < 8; b++) begin
      if (k[8*b +: 8] >= 8'h41 && k[8*b +: 8] <= 8'h5a) r[8*b +: 8] = k[8*b +: 8] + 8'h20;
    end
    return r;
  endfunction

  // Apply one command to the shadow table and return the reply it should give.
  function automatic reply_t table_update(input logic [CW-1:0] op, input logic [KW-1:0] raw,
                                          input logic [IW-1:0] idx);
    reply_t        r;
    logic [KW-1:0] key;
    logic [KW-1:0] cur;
    int unsigned   pos;
    int            j;
    r = '0;
    key = trim_name(raw);
    case (op)
      snt_pkg::CmdAppend: begin
        if (shadow_count < Depth) begin
          shadow_names[shadow_count] = key;
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      snt_pkg::CmdInsert: begin
        if (shadow_count < Depth) begin
          pos = shadow_count;
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_names[i] > key) begin
              pos = i;
              break;
            end
          end
          for (int i = shadow_count; i > pos; i--) shadow_names[i] = shadow_names[i-1];
          shadow_names[pos] = key;
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      snt_pkg::CmdRemove: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_names[i] == key) begin
            for (int m = i; m + 1 < shadow_count; m++) shadow_names[m] = shadow_names[m+1];
            shadow_count--;
            r.ok = 1'b1;
            break;
          end
        end
      end
      snt_pkg::CmdSort: begin
        for (int i = 1; i < shadow_count; i++) begin
          cur = shadow_names[i];
          j = i;
          while (j > 0 && lower_name(shadow_names[j-1]) > lower_name(cur)) begin
            shadow_names[j] = shadow_names[j-1];
            j--;
          end
          shadow_names[j] = cur;
        end
        r.ok = 1'b1;
      end
      snt_pkg::CmdRead: begin
        if (idx < shadow_count) begin
          r.value = shadow_names[idx];
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.total = shadow_count[snt_pkg::TotalWidth-1:0];
    return r;
  endfunction

  // Send one command, idling first at the current rate.
  task automatic send_cmd(input logic [CW-1:0] op, input logic [KW-1:0] key,
                          input logic [IW-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.cmd        <= op;
    cmd_bus.name_key   <= key;
    cmd_bus.read_index <= idx;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    pending_replies.push_back(table_update(op, key, idx));
  endtask

  // Random printable-ish name: mostly letters, some short, some with junk past a zero.
  function automatic logic [KW-1:0] random_name();
    logic [KW-1:0] k;
    int            len;
    k = {$urandom, $urandom};
    if ($urandom_range(9) < 2) return k;
    len = $urandom_range(8, 1);
    for (int b = 0; b < 8; b++) begin
      if (b < len) begin
        k[56-8*b +: 8] = $urandom_range(1) ? 8'(8'h41 + $urandom_range(3))
                                           : 8'(8'h61 + $urandom_range(3));
      end else if (b == len) begin
        k[56-8*b +: 8] = 8'h00;
      end
    end
    return k;
  endfunction

  task automatic drain_replies();
    cmd_bus.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Read back every entry plus one past the end while the table is not full.
  task automatic read_all();
    for (int i = 0; i <= shadow_count && i < Depth; i++) begin
      send_cmd(snt_pkg::CmdRead, '0, i[IW-1:0]);
    end
  endtask

  task automatic test_directed();
    send_cmd(snt_pkg::CmdRead, '0, '0);
    send_cmd(snt_pkg::CmdRemove, 64'h4142_0000_0000_0000, '0);
    send_cmd(snt_pkg::CmdSort, '0, '0);
    send_cmd(snt_pkg::CmdAppend, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_cmd(snt_pkg::CmdAppend, '0, '0);
    send_cmd(snt_pkg::CmdInsert, 64'h6162_0000_0000_0000, '0);
    send_cmd(snt_pkg::CmdInsert, 64'h6100_FFFF_0000_0000, '0);
    send_cmd(snt_pkg::CmdInsert, 64'h4243_0000_0000_0000, '0);
    send_cmd(snt_pkg::CmdInsert, 64'h0000_0000_0000_0001, '0);
    send_cmd(snt_pkg::CmdSort, '0, '0);
    read_all();
    send_cmd(snt_pkg::CmdRemove, 64'h6100_1234_0000_0000, '0);
    send_cmd(snt_pkg::CmdRemove, 64'h7A00_0000_0000_0000, '0);
    send_cmd(CmdUnusedLo, 64'h41, 5'd1);
    send_cmd(CmdUnusedHi, '1, '1);
    send_cmd(snt_pkg::CmdRead, '0, 5'd31);
  endtask

  // Fill to full, bounce off it, sort and read the whole table, then remove every name.
  task automatic test_full_table();
    while (shadow_count < Depth) begin
      send_cmd($urandom_range(1) ? snt_pkg::CmdAppend : snt_pkg::CmdInsert,
               random_name(), '0);
    end
    send_cmd(snt_pkg::CmdAppend, random_name(), '0);
    send_cmd(snt_pkg::CmdInsert, random_name(), '0);
    send_cmd(snt_pkg::CmdSort, '0, '0);
    read_all();
    drain_replies();
    while (shadow_count > 0) begin
      send_cmd(snt_pkg::CmdRemove, shadow_names[$urandom_range(shadow_count-1)], '0);
    end
  endtask

  // Random mix; removes mostly hit a held name.
  task automatic test_random_mix(input int items);
    logic [CW-1:0] op;
    logic [KW-1:0] key;
    for (int n = 0; n < items; n++) begin
      op = $urandom_range(99) < 3 ? 3'($urandom_range(CmdUnusedHi, CmdUnusedLo))
                                  : 3'($urandom_range(4));
      key = random_name();
      if (op == snt_pkg::CmdRemove && shadow_count > 0 && $urandom_range(3) != 0) begin
        key = shadow_names[$urandom_range(shadow_count-1)];
      end
      if (op == snt_pkg::CmdSort && $urandom_range(3) != 0) op = snt_pkg::CmdRead;
      send_cmd(op, key, 5'($urandom));
    end
  endtask

  // Check each reply against the oldest expectation.
  always @(posedge clk_i) begin
    if (rsp_bus.valid && rsp_bus.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply ok=%0b value=%h total=%0d", $time,
                 rsp_bus.ok, rsp_bus.entry_value, rsp_bus.entry_total);
        error_count++;
      end else begin
        if (pending_replies[0] !== {rsp_bus.ok, rsp_bus.entry_value, rsp_bus.entry_total}) begin
          $display("%0t: expected ok=%0b value=%h total=%0d, got ok=%0b value=%h total=%0d",
                   $time, pending_replies[0].ok, pending_replies[0].value,
                   pending_replies[0].total, rsp_bus.ok, rsp_bus.entry_value,
                   rsp_bus.entry_total);
          error_count++;
        end
        void'(pending_replies.pop_front());
      end
    end
  end

  // Receiver stalls at the current rate.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk_i) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("sorted_name_table_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cmd_bus.valid      = 1'b0;
    cmd_bus.cmd        = '0;
    cmd_bus.name_key   = '0;
    cmd_bus.read_index = '0;
    shadow_count       = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    rst_ni             = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_table();
    test_random_mix(400);
    // Sender holds off until the table has answered everything.
    drain_replies();
    send_idle_pct = 53;
    test_random_mix(400);
    send_idle_pct = 0;
    recv_stall_pct = 53;
    test_random_mix(400);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    test_full_table();
    test_random_mix(350);

    drain_replies();
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("sorted_name_table_core test passed");
    end else begin
      $display("sorted_name_table_core test failed");
    end
    $finish;
  end

endmodule
